@@ src/ps2hl_pkg.sv @@
package ps2hl_pkg;

  // Command codes carried in the low bits of the input beat
  typedef enum logic [2:0] {
    CMD_EDGE    = 3'd0,
    CMD_SEND    = 3'd1,
    CMD_RELEASE = 3'd2,
    CMD_POP     = 3'd3,
    CMD_CLEAR   = 3'd4,
    CMD_ABORT   = 3'd5
  } cmd_t;

  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned TX_CNT_W       = 4;
  localparam int unsigned RX_CNT_W       = 4;
  localparam int unsigned IN_TDATA_W     = 16;
  localparam int unsigned OUT_TDATA_W    = 16;

  // Send frame: 8 data bits, parity, stop
  localparam logic [TX_CNT_W-1:0] TX_FRAME_BITS  = 4'd10;
  localparam logic [TX_CNT_W-1:0] TX_PARITY_SLOT = 4'd1;
  localparam logic [TX_CNT_W-1:0] TX_STOP_SLOT   = 4'd0;
  // Receive frame: start, 8 data, parity, stop
  localparam logic [RX_CNT_W-1:0] RX_FIRST_DATA  = 4'd1;
  localparam logic [RX_CNT_W-1:0] RX_LAST_DATA   = 4'd8;
  localparam logic [RX_CNT_W-1:0] RX_FRAME_EDGES = 4'd11;

  // Link status carried with each result
  typedef struct packed {
    logic data_level;
    logic drive_data;
    logic send_busy;
    logic ack_pending;
    logic rx_valid;
    logic rx_pending;
    logic overflow;
  } status_t;

endpackage

@@ src/ps2hl_ram.sv @@
module ps2hl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/ps2_host_link_with_rx_fifo.sv @@
// PS/2 host link with receive FIFO held in a one-port-read, one-port-write RAM.
// A result beat passes through the registered FIFO read, alongside the status register,
// and then through the output register.
// Throughput: one beat per cycle while out_tready does not hold the output; each accepted event updates the link state.
// Reset (rst_n low, synchronous) clears link state, pointers and the pipeline;
// the FIFO storage is not cleared, since only written entries are ever popped.
module ps2_host_link_with_rx_fifo
  import ps2hl_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [2:0] cmd, [3] data_line, [11:4] tx_byte, [15:12] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] data_level, [1] drive_data, [2] send_busy, [3] ack_pending,
  // [11:4] rx_byte, [12] rx_valid, [13] rx_pending, [14] overflow, [15] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

  // Input beat fields
  cmd_t              cmd;
  logic              din;
  logic [BYTE_W-1:0] tx_byte;

  assign cmd     = cmd_t'(in_tdata[2:0]);
  assign din     = in_tdata[3];
  assign tx_byte = in_tdata[11:4];

  // Link state
  logic [BYTE_W-1:0]   tx_shift_r, tx_shift_nxt;
  logic [TX_CNT_W-1:0] tx_bits_left_r, tx_bits_left_nxt;
  logic                tx_ones_odd_r, tx_ones_odd_nxt;
  logic                awaiting_ack_r, awaiting_ack_nxt;
  logic                line_level_r, line_level_nxt;
  logic                line_driven_r, line_driven_nxt;
  logic [BYTE_W-1:0]   rx_shift_r, rx_shift_nxt;
  logic [RX_CNT_W-1:0] rx_edge_count_r, rx_edge_count_nxt;
  logic [PTR_W-1:0]    read_ptr_r, read_ptr_nxt;
  logic [PTR_W-1:0]    write_ptr_r, write_ptr_nxt;
  logic [CNT_W-1:0]    fill_count_r, fill_count_nxt;

  // Pipeline
  logic              s1_valid_r;
  status_t           s1_stat_r;
  status_t           stat_nxt;
  logic              out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic              s1_advance;
  logic              accept;

  // FIFO access
  logic              push_en;
  logic              pop_en;
  logic [BYTE_W-1:0] push_byte;
  logic [BYTE_W-1:0] ram_rdata;
  logic              ovf;

  logic [TX_CNT_W-1:0] tx_cnt_dec;
  logic [RX_CNT_W-1:0] rx_cnt_inc;
  logic [BYTE_W-1:0]   rx_shift_in;

  assign s1_advance = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_advance;
  assign accept     = in_tvalid && in_tready;

  assign tx_cnt_dec  = tx_bits_left_r - TX_CNT_W'(1);
  assign rx_cnt_inc  = rx_edge_count_r + RX_CNT_W'(1);
  assign rx_shift_in = ((rx_edge_count_r >= RX_FIRST_DATA) && (rx_edge_count_r <= RX_LAST_DATA))
                       ? {din, rx_shift_r[BYTE_W-1:1]} : rx_shift_r;

  // Event decode and link state update
  always_comb begin
    tx_shift_nxt      = tx_shift_r;
    tx_bits_left_nxt  = tx_bits_left_r;
    tx_ones_odd_nxt   = tx_ones_odd_r;
    awaiting_ack_nxt  = awaiting_ack_r;
    line_level_nxt    = line_level_r;
    line_driven_nxt   = line_driven_r;
    rx_shift_nxt      = rx_shift_r;
    rx_edge_count_nxt = rx_edge_count_r;
    read_ptr_nxt      = read_ptr_r;
    write_ptr_nxt     = write_ptr_r;
    fill_count_nxt    = fill_count_r;
    push_en           = 1'b0;
    push_byte         = rx_shift_in;
    pop_en            = 1'b0;
    ovf               = 1'b0;

    unique case (cmd)
      CMD_EDGE: begin
        priority if (awaiting_ack_r) begin
          if (!din) begin
            awaiting_ack_nxt = 1'b0;
          end
        end else if (tx_bits_left_r != '0) begin
          // Drive the next bit of the send frame
          tx_bits_left_nxt = tx_cnt_dec;
          priority if (tx_cnt_dec == TX_PARITY_SLOT) begin
            line_level_nxt = !tx_ones_odd_r;
          end else if (tx_cnt_dec == TX_STOP_SLOT) begin
            line_level_nxt = 1'b1;
          end else begin
            line_level_nxt  = tx_shift_r[0];
            tx_ones_odd_nxt = tx_ones_odd_r ^ tx_shift_r[0];
            tx_shift_nxt    = {1'b0, tx_shift_r[BYTE_W-1:1]};
          end
        end else begin
          // Deframe a received bit
          rx_shift_nxt      = rx_shift_in;
          rx_edge_count_nxt = rx_cnt_inc;
          if (rx_cnt_inc >= RX_FRAME_EDGES) begin
            rx_edge_count_nxt = '0;
            rx_shift_nxt      = '0;
            if (fill_count_r >= CNT_FULL) begin
              ovf = 1'b1;
            end else begin
              push_en        = 1'b1;
              write_ptr_nxt  = (write_ptr_r == PTR_LAST) ? '0 : write_ptr_r + PTR_W'(1);
              fill_count_nxt = fill_count_r + CNT_W'(1);
            end
          end
        end
      end
      CMD_SEND: begin
        tx_shift_nxt     = tx_byte;
        tx_bits_left_nxt = TX_FRAME_BITS;
        tx_ones_odd_nxt  = 1'b0;
        awaiting_ack_nxt = 1'b0;
        line_level_nxt   = 1'b0;
        line_driven_nxt  = 1'b1;
      end
      CMD_RELEASE: begin
        if (tx_bits_left_r == '0) begin
          line_driven_nxt  = 1'b0;
          awaiting_ack_nxt = 1'b1;
        end
      end
      CMD_POP: begin
        if (fill_count_r != '0) begin
          pop_en         = 1'b1;
          read_ptr_nxt   = (read_ptr_r == PTR_LAST) ? '0 : read_ptr_r + PTR_W'(1);
          fill_count_nxt = fill_count_r - CNT_W'(1);
        end
      end
      CMD_CLEAR: begin
        read_ptr_nxt   = write_ptr_r;
        fill_count_nxt = '0;
      end
      CMD_ABORT: begin
        tx_bits_left_nxt = '0;
        awaiting_ack_nxt = 1'b0;
        line_driven_nxt  = 1'b0;
      end
      default: begin
      end
    endcase

    stat_nxt.data_level  = line_level_nxt;
    stat_nxt.drive_data  = line_driven_nxt;
    stat_nxt.send_busy   = (tx_bits_left_nxt != '0);
    stat_nxt.ack_pending = awaiting_ack_nxt;
    stat_nxt.rx_valid    = pop_en;
    stat_nxt.rx_pending  = (fill_count_nxt != '0);
    stat_nxt.overflow    = ovf;
  end

  // Receive FIFO storage; a byte is always written before the pop that reads it
  ps2hl_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FIFO_DEPTH)
  ) u_rx_ram (
    .clk   (clk),
    .we    (accept && push_en),
    .waddr (write_ptr_r),
    .wdata (push_byte),
    .re    (accept && pop_en),
    .raddr (read_ptr_r),
    .rdata (ram_rdata)
  );

  // Hold link state, advance on accepted beats
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_shift_r      <= '0;
      tx_bits_left_r  <= '0;
      tx_ones_odd_r   <= 1'b0;
      awaiting_ack_r  <= 1'b0;
      line_level_r    <= 1'b1;
      line_driven_r   <= 1'b0;
      rx_shift_r      <= '0;
      rx_edge_count_r <= '0;
      read_ptr_r      <= '0;
      write_ptr_r     <= '0;
      fill_count_r    <= '0;
    end else if (accept) begin
      tx_shift_r      <= tx_shift_nxt;
      tx_bits_left_r  <= tx_bits_left_nxt;
      tx_ones_odd_r   <= tx_ones_odd_nxt;
      awaiting_ack_r  <= awaiting_ack_nxt;
      line_level_r    <= line_level_nxt;
      line_driven_r   <= line_driven_nxt;
      rx_shift_r      <= rx_shift_nxt;
      rx_edge_count_r <= rx_edge_count_nxt;
      read_ptr_r      <= read_ptr_nxt;
      write_ptr_r     <= write_ptr_nxt;
      fill_count_r    <= fill_count_nxt;
    end
  end

  // Read stage: wait for the registered FIFO read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_stat_r <= stat_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_data_r <= {1'b0,
                     s1_stat_r.overflow,
                     s1_stat_r.rx_pending,
                     s1_stat_r.rx_valid,
                     s1_stat_r.rx_valid ? ram_rdata : {BYTE_W{1'b0}},
                     s1_stat_r.ack_pending,
                     s1_stat_r.send_busy,
                     s1_stat_r.drive_data,
                     s1_stat_r.data_level};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ tb/tb_ps2_host_link_with_rx_fifo.sv @@
`timescale 1ns / 100ps

module tb_ps2_host_link_with_rx_fifo;
  import ps2hl_pkg::*;

  localparam int unsigned RX_DEPTH         = 32;
  localparam int unsigned TOTAL_EVENTS     = 950;
  localparam int unsigned FILL_AT          = 300;
  localparam int unsigned CALM_AT          = 830;
  localparam int unsigned LONG_HOLD_CYCLES = 200;
  localparam int unsigned STALL_LIMIT      = 2000;
  localparam int unsigned DRAIN_CYCLES     = 10;
  localparam int unsigned REPORT_LIMIT     = 10;

  // Command codes the block treats as no-ops
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  // Result beat layout, MSB first, matching out_tdata
  typedef struct packed {
    logic       spare;
    logic       overflow;
    logic       rx_pending;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       ack_pending;
    logic       send_busy;
    logic       drive_data;
    logic       data_level;
  } link_status_t;

  typedef struct {
    logic [2:0]   op;
    logic         din;
    logic [7:0]   tx;
    bit           fixed;
    link_status_t want;
  } directed_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // [2:0] cmd, [3] data_line, [11:4] tx_byte, [15:12] zero
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [0] data_level, [1] drive_data, [2] send_busy, [3] ack_pending,
  // [11:4] rx_byte, [12] rx_valid, [13] rx_pending, [14] overflow, [15] zero
  logic [OUT_TDATA_W-1:0] out_tdata;

  link_status_t  expected_status[$];
  directed_row_t directed_rows[$];
  int unsigned   events_sent = 0;
  int unsigned   mismatch_count = 0;
  bit            calm = 1'b0;
  bit            hold_off_req = 1'b0;

  // Link model state
  logic [7:0] tx_shift;
  logic [3:0] tx_left;
  logic       tx_odd;
  logic       ack_wait;
  logic       line_lvl;
  logic       line_drv;
  logic [7:0] rx_shift;
  logic [3:0] rx_edges;
  logic [7:0] rx_fifo[$];

  link_status_t want_q;
  link_status_t got_q;

  ps2_host_link_with_rx_fifo #(
    .FIFO_DEPTH (RX_DEPTH)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Advance the link model by one event and return the status it shows
  function automatic link_status_t ps2_link_step(logic [2:0] op, logic din, logic [7:0] tx_in);
    link_status_t st;
    st = '0;
    case (op)
      CMD_EDGE: begin
        if (ack_wait) begin
          if (!din) ack_wait = 1'b0;
        end else if (tx_left != '0) begin
          tx_left = tx_left - 4'd1;
          if (tx_left == TX_PARITY_SLOT) begin
            line_lvl = ~tx_odd;
          end else if (tx_left == TX_STOP_SLOT) begin
            line_lvl = 1'b1;
          end else begin
            line_lvl = tx_shift[0];
            tx_odd   = tx_odd ^ tx_shift[0];
            tx_shift = tx_shift >> 1;
          end
        end else begin
          // Deframe: data bits arrive LSB first on edges one to eight
          if (rx_edges >= RX_FIRST_DATA && rx_edges <= RX_LAST_DATA)
            rx_shift = {din, rx_shift[7:1]};
          rx_edges = rx_edges + 4'd1;
          if (rx_edges == RX_FRAME_EDGES) begin
            rx_edges = '0;
            if (rx_fifo.size() >= RX_DEPTH) st.overflow = 1'b1;
            else rx_fifo.push_back(rx_shift);
            rx_shift = '0;
          end
        end
      end
      CMD_SEND: begin
        tx_shift = tx_in;
        tx_left  = TX_FRAME_BITS;
        tx_odd   = 1'b0;
        ack_wait = 1'b0;
        line_lvl = 1'b0;
        line_drv = 1'b1;
      end
      CMD_RELEASE: begin
        if (tx_left == '0) begin
          line_drv = 1'b0;
          ack_wait = 1'b1;
        end
      end
      CMD_POP: begin
        if (rx_fifo.size() > 0) begin
          st.rx_byte  = rx_fifo.pop_front();
          st.rx_valid = 1'b1;
        end
      end
      CMD_CLEAR: rx_fifo.delete();
      CMD_ABORT: begin
        tx_left  = '0;
        ack_wait = 1'b0;
        line_drv = 1'b0;
      end
      default: ;
    endcase
    st.data_level  = line_lvl;
    st.drive_data  = line_drv;
    st.send_busy   = (tx_left != '0);
    st.ack_pending = ack_wait;
    st.rx_pending  = (rx_fifo.size() > 0);
    return st;
  endfunction

  function automatic link_status_t line_status(logic lvl, logic drv, logic busy);
    link_status_t st;
    st = '0;
    st.data_level = lvl;
    st.drive_data = drv;
    st.send_busy  = busy;
    return st;
  endfunction

  task automatic add_row(logic [2:0] op, logic din, logic [7:0] tx, bit fixed,
                         link_status_t want);
    directed_row_t row;
    row.op    = op;
    row.din   = din;
    row.tx    = tx;
    row.fixed = fixed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // Offer one event beat, hold it until accepted, then queue its status
  task automatic issue_event(logic [2:0] op, logic din, logic [7:0] tx, bit fixed,
                             link_status_t want);
    link_status_t predicted;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, tx, din, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = ps2_link_step(op, din, tx);
    expected_status.push_back(fixed ? want : predicted);
    events_sent++;
  endtask

  task automatic issue_edge(logic din);
    issue_event(CMD_EDGE, din, 8'($urandom), 1'b0, '0);
  endtask

  // Device-to-host frame: start, data LSB first, parity, stop; a broken frame stops early
  task automatic receive_frame(bit broken);
    logic [10:0] frame;
    int unsigned n_edges;
    frame   = {1'b1, 1'($urandom), 8'($urandom), 1'b0};
    n_edges = broken ? $urandom_range(1, 10) : 11;
    for (int i = 0; i < n_edges; i++) issue_edge(frame[i]);
  endtask

  // Host-to-device transfer: request, up to ten bit edges, then an abort, or a release and ack edges, or neither
  task automatic send_frame();
    int unsigned n_bits;
    issue_event(CMD_SEND, 1'($urandom), 8'($urandom), 1'b0, '0);
    n_bits = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 9) : 10;
    for (int i = 0; i < n_bits; i++) issue_edge(1'($urandom));
    if (n_bits < 10 && $urandom_range(0, 1) == 0) begin
      issue_event(CMD_ABORT, 1'($urandom), 8'($urandom), 1'b0, '0);
    end else if ($urandom_range(0, 3) != 0) begin
      issue_event(CMD_RELEASE, 1'($urandom), 8'($urandom), 1'b0, '0);
      repeat ($urandom_range(1, 3)) issue_edge(1'($urandom));
    end
  endtask

  task automatic issue_pops(int unsigned n);
    repeat (n) issue_event(CMD_POP, 1'($urandom), 8'($urandom), 1'b0, '0);
  endtask

  // Stimulus
  initial begin
    logic [2:0] op;

    tx_shift = '0; tx_left = '0; tx_odd = 1'b0; ack_wait = 1'b0;
    line_lvl = 1'b1; line_drv = 1'b0; rx_shift = '0; rx_edges = '0;
    rx_fifo.delete();

    // Directed: send all ones with ack, send zero then abort, spares, FIFO ops
    add_row(CMD_POP, 1'b1, 8'hA5, 1'b1, line_status(1'b1, 1'b0, 1'b0));
    add_row(CMD_SEND, 1'b0, 8'hFF, 1'b1, line_status(1'b0, 1'b1, 1'b1));
    for (int i = 0; i < 10; i++) add_row(CMD_EDGE, i[0], 8'h00, 1'b0, '0);
    add_row(CMD_RELEASE, 1'b0, 8'h00, 1'b0, '0);
    add_row(CMD_EDGE, 1'b1, 8'hFF, 1'b0, '0);
    add_row(CMD_EDGE, 1'b0, 8'h00, 1'b0, '0);
    add_row(CMD_SEND, 1'b1, 8'h00, 1'b1, line_status(1'b0, 1'b1, 1'b1));
    add_row(CMD_RELEASE, 1'b1, 8'hFF, 1'b1, line_status(1'b0, 1'b1, 1'b1));
    add_row(CMD_ABORT, 1'b0, 8'h00, 1'b1, line_status(1'b0, 1'b0, 1'b0));
    add_row(CMD_SPARE6, 1'b1, 8'hFF, 1'b1, line_status(1'b0, 1'b0, 1'b0));
    add_row(CMD_SPARE7, 1'b0, 8'h00, 1'b1, line_status(1'b0, 1'b0, 1'b0));
    add_row(CMD_CLEAR, 1'b1, 8'h80, 1'b1, line_status(1'b0, 1'b0, 1'b0));
    add_row(CMD_POP, 1'b0, 8'h01, 1'b1, line_status(1'b0, 1'b0, 1'b0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      issue_event(directed_rows[i].op, directed_rows[i].din, directed_rows[i].tx,
                  directed_rows[i].fixed, directed_rows[i].want);

    // Random mix; once, hold off the receiver, then fill the FIFO past full
    // and drain it
    while (events_sent < TOTAL_EVENTS) begin
      if (events_sent >= CALM_AT) calm = 1'b1;
      if (events_sent >= FILL_AT && !hold_off_req) begin
        hold_off_req = 1'b1;
        repeat (RX_DEPTH + 3) receive_frame(1'b0);
        issue_pops(RX_DEPTH + 2);
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: receive_frame($urandom_range(0, 7) == 0);
          4, 5:       send_frame();
          6, 7:       issue_pops($urandom_range(1, 3));
          8: begin
            repeat ($urandom_range(1, 4)) begin
              op = 3'($urandom_range(CMD_EDGE, CMD_SPARE7));
              issue_event(op, 1'($urandom), 8'($urandom), 1'b0, '0);
            end
          end
          default: begin
            case ($urandom_range(0, 4))
              0:       op = CMD_CLEAR;
              1:       op = CMD_ABORT;
              2:       op = CMD_SPARE6;
              3:       op = CMD_SPARE7;
              default: op = CMD_RELEASE;
            endcase
            issue_event(op, 1'($urandom), 8'($urandom), 1'b0, '0);
          end
        endcase
      end
    end
    in_tvalid <= 1'b0;

    // Wait for every status beat, then let the pipeline settle
    while (expected_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Receiver: random back-pressure, one long hold-off, none near the end
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
        out_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic note_mismatch(string what, link_status_t want, link_status_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("mismatch (%s) at %0t", what, $time);
      $display("  expected lvl=%b drv=%b busy=%b ack=%b byte=%h vld=%b pend=%b ovf=%b",
               want.data_level, want.drive_data, want.send_busy, want.ack_pending,
               want.rx_byte, want.rx_valid, want.rx_pending, want.overflow);
      $display("  got      lvl=%b drv=%b busy=%b ack=%b byte=%h vld=%b pend=%b ovf=%b",
               got.data_level, got.drive_data, got.send_busy, got.ack_pending,
               got.rx_byte, got.rx_valid, got.rx_pending, got.overflow);
    end
  endtask

  // Compare each accepted status beat with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_q = out_tdata;
      if (expected_status.size() == 0) begin
        note_mismatch("unexpected beat", '0, got_q);
      end else begin
        want_q = expected_status.pop_front();
        if (got_q.data_level  !== want_q.data_level  ||
            got_q.drive_data  !== want_q.drive_data  ||
            got_q.send_busy   !== want_q.send_busy   ||
            got_q.ack_pending !== want_q.ack_pending ||
            got_q.rx_byte     !== want_q.rx_byte     ||
            got_q.rx_valid    !== want_q.rx_valid    ||
            got_q.rx_pending  !== want_q.rx_pending  ||
            got_q.overflow    !== want_q.overflow)
          note_mismatch("field", want_q, got_q);
      end
    end
  end

  // Watchdog: end the run when no beat moves on either side for too long
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
